// File: rtl/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg: shared constants and types for the bounded step path counter
// Widths, window sizing and the control word that steers the cell row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsp_pkg;

  localparam int unsigned MaxStepLimit = 64;
  localparam int unsigned RungBits     = 20;
  localparam int unsigned WordBits     = 64;
  localparam int unsigned StepBits     = 7;

  // one cell per window entry, the last cell is the fixed tap of the oldest value
  localparam int unsigned CellCount = MaxStepLimit + 1;
  localparam int unsigned PosBits   = $clog2(CellCount);

  typedef logic [WordBits-1:0] word_t;

  typedef struct packed {
    logic clear;   // start of a request: wipe the window
    logic shift;   // one recurrence step: move values one cell along
    logic inject;  // this cell is the entry point of the window
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/bsp_if.sv
// ----------------------------------------------------------------------------
// bsp_if: request and response channels of the bounded step path counter
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bsp_req_if;
  logic                         valid;
  logic                         ready;
  logic [bsp_pkg::RungBits-1:0] rung_count;

  modport source (output valid, output rung_count, input ready);
  modport sink   (input valid, input rung_count, output ready);
endinterface

interface bsp_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bsp_pkg::WordBits-1:0] way_count;
  logic                         overflow;

  modport source (output valid, output way_count, output overflow, input ready);
  modport sink   (input valid, input way_count, input overflow, output ready);
endinterface

`default_nettype wire

// File: rtl/bsp_cell.sv
// ----------------------------------------------------------------------------
// bsp_cell: one entry of the shifting history window
// Holds one past count; takes its neighbor's value or a fresh one each step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsp_cell (
  input  wire                 clk_i,
  input  bsp_pkg::cell_ctrl_t ctrl_i,
  input  bsp_pkg::word_t      load_i,
  input  bsp_pkg::word_t      shift_i,
  output bsp_pkg::word_t      value_o
);

  bsp_pkg::word_t value_q;
  bsp_pkg::word_t value_d;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.clear || ctrl_i.shift) begin
      if (ctrl_i.inject) begin
        value_d = load_i;
      end else if (ctrl_i.clear) begin
        value_d = '0;
      end else begin
        value_d = shift_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

// File: rtl/bounded_step_path_counter.sv
// ----------------------------------------------------------------------------
// bounded_step_path_counter: ways to climb N rungs with moves of 1..K rungs
// K-bonacci recurrence over a row of history cells, one step per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries a ladder height rung_count; rsp_o returns way_count (the
//   count modulo 2^64) and overflow (set once the true count passed 2^64-1).
//   max_step (K) is written through cfg_we_i/cfg_wdata_i while idle; 0 acts
//   as 1 and values above 64 act as 64. Reset value of K is 2.
// Timing:
//   a request is taken in idle, then the recurrence runs N steps, one
//   per cycle, through a row of 65 history cells; the newest count
//   enters the cell at position 64-K and the oldest needed count leaves
//   from the last cell. The response is registered when the run ends,
//   or from the hold state once the output register is free. A new
//   request is taken only in idle, after the previous run has finished.
// Stall and reset:
//   a waiting response does not block the next request; if a new result
//   is done while the old one is still held, the block waits until it is
//   taken. Reset leaves the block idle with no response pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_step_path_counter (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [bsp_pkg::StepBits-1:0]   cfg_wdata_i,
  bsp_req_if.sink                       req_i,
  bsp_rsp_if.source                     rsp_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StHold = 3'b100
  } state_e;

  localparam logic [bsp_pkg::StepBits-1:0] StepMax =
    bsp_pkg::StepBits'(bsp_pkg::MaxStepLimit);
  localparam logic [bsp_pkg::StepBits-1:0] StepOne = bsp_pkg::StepBits'(1);
  localparam logic [bsp_pkg::PosBits-1:0]  LastPos =
    bsp_pkg::PosBits'(bsp_pkg::CellCount - 1);
  localparam logic [bsp_pkg::RungBits-1:0] RungOne = bsp_pkg::RungBits'(1);

  state_e                         state_q, state_d;
  logic [bsp_pkg::StepBits-1:0]   max_step_q;
  logic [bsp_pkg::StepBits-1:0]   eff_step;
  logic [bsp_pkg::PosBits-1:0]    inj_pos_q;
  logic [bsp_pkg::RungBits-1:0]   rung_q;
  logic [bsp_pkg::RungBits-1:0]   idx_q;
  bsp_pkg::word_t                 prev_q;
  logic                           wrap_q;
  bsp_pkg::word_t                 way_q;
  logic                           ovf_q;
  logic                           out_valid_q;

  logic           req_fire;
  logic           step_en;
  logic           last_cycle;
  logic           out_free;
  logic           out_load;
  bsp_pkg::word_t step_val;
  bsp_pkg::word_t cell_load;
  logic           step_wrap;
  bsp_pkg::word_t fin_val;
  logic           fin_wrap;

  bsp_pkg::word_t cell_val [bsp_pkg::CellCount];

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_q <= bsp_pkg::StepBits'(2);
    end else if (cfg_we_i) begin
      max_step_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (max_step_q == '0) begin
      eff_step = StepOne;
    end else if (max_step_q > StepMax) begin
      eff_step = StepMax;
    end else begin
      eff_step = max_step_q;
    end
  end

  assign req_i.ready = (state_q == StIdle);
  assign req_fire    = req_i.valid && req_i.ready;
  assign step_en     = (state_q == StRun) && (rung_q != '0);
  assign last_cycle  = (rung_q == '0) || (idx_q == rung_q);
  assign out_free    = !out_valid_q || rsp_o.ready;

  // dp[1] is forced to one, later steps use 2*dp[i-1] - dp[i-K-1]
  assign step_val  = (idx_q == RungOne) ? bsp_pkg::word_t'(1)
                                        : (prev_q << 1) - cell_val[bsp_pkg::CellCount-1];
  assign step_wrap = step_val < prev_q;
  assign cell_load = req_fire ? bsp_pkg::word_t'(1) : step_val;

  assign fin_val  = step_en ? step_val : prev_q;
  assign fin_wrap = wrap_q || (step_en && step_wrap);

  // history cell row
  for (genvar j = 0; j < bsp_pkg::CellCount; j++) begin : g_cell
    bsp_pkg::cell_ctrl_t ctrl;
    bsp_pkg::word_t      from_prev;

    assign ctrl.clear  = req_fire;
    assign ctrl.shift  = step_en;
    assign ctrl.inject = req_fire
                         ? (bsp_pkg::PosBits'(j) == LastPos - bsp_pkg::PosBits'(eff_step))
                         : (bsp_pkg::PosBits'(j) == inj_pos_q);

    if (j == 0) begin : g_first
      assign from_prev = '0;
    end else begin : g_rest
      assign from_prev = cell_val[j-1];
    end

    bsp_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .load_i  (cell_load),
      .shift_i (from_prev),
      .value_o (cell_val[j])
    );
  end

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (req_fire) begin
          state_d = StRun;
        end
      end
      StRun: begin
        if (last_cycle) begin
          if (out_free) begin
            out_load = 1'b1;
            state_d  = StIdle;
          end else begin
            state_d = StHold;
          end
        end
      end
      StHold: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      wrap_q      <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (req_fire) begin
        wrap_q <= 1'b0;
        idx_q  <= RungOne;
      end else if (step_en) begin
        wrap_q <= fin_wrap;
        idx_q  <= idx_q + RungOne;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      rung_q    <= req_i.rung_count;
      inj_pos_q <= LastPos - bsp_pkg::PosBits'(eff_step);
      prev_q    <= bsp_pkg::word_t'(1);
    end else if (step_en) begin
      prev_q <= step_val;
    end
    if (out_load) begin
      way_q <= (state_q == StRun) ? fin_val : prev_q;
      ovf_q <= (state_q == StRun) ? fin_wrap : wrap_q;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.way_count = way_q;
  assign rsp_o.overflow  = ovf_q;

  // a request always starts the recurrence in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q == StRun))
    else $error("request did not start the recurrence");

  // the block only parks a result while the output register is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StHold) |-> out_valid_q)
    else $error("result parked with an empty output register");

  // the step counter never runs past the requested height
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en |-> (idx_q != '0) && (idx_q <= rung_q))
    else $error("step counter out of range");

  // a finished run leaves a response pending in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("finished result not presented");

endmodule

`default_nettype wire

// File: tb/bsp_way_checker.sv
// ----------------------------------------------------------------------------
// bsp_way_checker: scoreboard for the bounded step path counter
// Tracks max_step writes, predicts way_count and overflow for every accepted
// request, and compares each accepted response with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsp_way_checker
  import bsp_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire [StepBits-1:0] cfg_wdata_i,
  bsp_req_if                 req,
  bsp_rsp_if                 rsp,
  output int                 pending_o,
  output int                 fail_count_o
);

  typedef struct packed {
    word_t way_count;
    logic  overflow;
  } way_result_t;

  way_result_t         expected_ways_q [$];
  logic [StepBits-1:0] step_setting;

  // k-bonacci walk over a ring of the last K+1 counts
  function automatic way_result_t climb_ways(logic [RungBits-1:0] rungs,
                                             logic [StepBits-1:0] step_reg);
    word_t       history [CellCount];
    int unsigned step;
    int unsigned ring_len;
    int unsigned head;
    word_t       prev;
    word_t       oldest;
    word_t       next_val;
    way_result_t res;
    step = int'(step_reg);
    if (step < 1) step = 1;
    if (step > MaxStepLimit) step = MaxStepLimit;
    ring_len = step + 1;
    foreach (history[j]) history[j] = '0;
    history[0] = word_t'(1);
    head = 1;
    prev = word_t'(1);
    res.overflow = 1'b0;
    for (int unsigned i = 1; i <= int'(rungs); i++) begin
      oldest = history[head];
      next_val = (i == 1) ? word_t'(1) : (prev << 1) - oldest;
      // the true count never drops, so a drop means it wrapped
      if (next_val < prev) res.overflow = 1'b1;
      history[head] = next_val;
      head++;
      if (head >= ring_len) head = 0;
      prev = next_val;
    end
    res.way_count = prev;
    return res;
  endfunction

  initial begin
    pending_o = 0;
    fail_count_o = 0;
    step_setting = 7'd2;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    way_result_t want;
    if (!rst_ni) begin
      expected_ways_q.delete();
      step_setting = 7'd2;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) step_setting = cfg_wdata_i;
      if (req.valid && req.ready) begin
        expected_ways_q.insert(expected_ways_q.size(),
                               climb_ways(req.rung_count, step_setting));
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_ways_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: response with no request outstanding: expected none, actual %0h/%0b",
                   $time, rsp.way_count, rsp.overflow);
        end else begin
          want = expected_ways_q.pop_front();
          if (rsp.way_count !== want.way_count) begin
            fail_count_o++;
            $display("%0t: way_count expected %0h actual %0h",
                     $time, want.way_count, rsp.way_count);
          end
          if (rsp.overflow !== want.overflow) begin
            fail_count_o++;
            $display("%0t: overflow expected %0b actual %0b",
                     $time, want.overflow, rsp.overflow);
          end
        end
      end
      pending_o <= expected_ways_q.size();
    end
  end

endmodule

`default_nettype wire

// File: tb/bounded_step_path_counter_tb.sv
// ----------------------------------------------------------------------------
// bounded_step_path_counter_tb: stimulus and verdict for the path counter
// Directed heights and step limits first, then random phases with random
// idling on both channels, one long response hold-off and drains between
// phases; the checker module does all prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_step_path_counter_tb;
  import bsp_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we;
  logic [StepBits-1:0] cfg_wdata;
  int                  pending_ways;
  int                  way_faults;
  int                  responses_taken;
  bit                  hold_done;

  bsp_req_if req_if ();
  bsp_rsp_if rsp_if ();

  bounded_step_path_counter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  bsp_way_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .req          (req_if),
    .rsp          (rsp_if),
    .pending_o    (pending_ways),
    .fail_count_o (way_faults)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #60_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // response side: random stalls, one long hold-off and one stall-free stretch
  initial begin
    rsp_if.ready <= 1'b0;
    responses_taken = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) responses_taken++;
      if (!hold_done && responses_taken >= 30) begin
        hold_done = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (600) @(posedge clk_i);
      end else if (responses_taken >= 60 && responses_taken < 90) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= 30);
      end
    end
  end

  task automatic offer_rungs(input logic [RungBits-1:0] rungs, input bit may_idle);
    int unsigned gap;
    req_if.valid <= 1'b1;
    req_if.rung_count <= rungs;
    do @(posedge clk_i); while (!req_if.ready);
    if (may_idle && $urandom_range(99) < 30) begin
      gap = $urandom_range(1, 6);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_results_in();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_ways != 0) @(posedge clk_i);
  endtask

  task automatic write_max_step(input logic [StepBits-1:0] step);
    wait_results_in();
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= step;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // mostly short ladders around the overflow point, a few long ones
  function automatic logic [RungBits-1:0] pick_rungs();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return RungBits'($urandom_range(0, 4000));
    if (roll < 15) return RungBits'($urandom_range(0, 3));
    return RungBits'($urandom_range(0, 160));
  endfunction

  function automatic logic [StepBits-1:0] pick_step();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 25) return StepBits'($urandom_range(0, 127));
    if (roll < 40) return StepBits'(MaxStepLimit);
    return StepBits'($urandom_range(2, 12));
  endfunction

  initial begin
    req_if.valid <= 1'b0;
    req_if.rung_count <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset step limit: fibonacci, wraps between heights 92 and 93
    offer_rungs(20'd0, 1'b1);
    offer_rungs(20'd1, 1'b1);
    offer_rungs(20'd2, 1'b1);
    offer_rungs(20'd3, 1'b1);
    offer_rungs(20'd92, 1'b1);
    offer_rungs(20'd93, 1'b1);
    offer_rungs(20'd94, 1'b1);
    offer_rungs(20'hFFFFF, 1'b1);

    // zero acts as a step of one
    write_max_step(7'd0);
    offer_rungs(20'd0, 1'b1);
    offer_rungs(20'd9, 1'b1);
    offer_rungs(20'd1000, 1'b1);
    write_max_step(7'd1);
    offer_rungs(20'd1, 1'b1);
    offer_rungs(20'd12, 1'b1);
    // all ones clamps to the largest step
    write_max_step(7'd127);
    offer_rungs(20'd63, 1'b1);
    offer_rungs(20'd64, 1'b1);
    offer_rungs(20'd65, 1'b1);
    offer_rungs(20'd66, 1'b1);
    offer_rungs(20'd200, 1'b1);
    write_max_step(7'd64);
    offer_rungs(20'd129, 1'b1);
    write_max_step(7'd65);
    offer_rungs(20'd70, 1'b1);
    write_max_step(7'd3);
    offer_rungs(20'd2, 1'b1);
    offer_rungs(20'd3, 1'b1);
    offer_rungs(20'd4, 1'b1);

    for (int phase = 0; phase < 5; phase++) begin
      write_max_step(pick_step());
      for (int item = 0; item < 20; item++) begin
        offer_rungs(pick_rungs(), phase != 2);
      end
    end

    wait_results_in();
    repeat (50) @(posedge clk_i);
    if (way_faults == 0 && pending_ways == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: bounded_step_path_counter.f
rtl/bsp_pkg.sv
rtl/bsp_if.sv
rtl/bsp_cell.sv
rtl/bounded_step_path_counter.sv
tb/bsp_way_checker.sv
tb/bounded_step_path_counter_tb.sv
